/* hdl/mvsm_pkg.sv */
`default_nettype none
package mvsm_pkg;

    localparam int VOICES_DEFAULT        = 4;
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int SAMPLE_WORDS_DEFAULT  = 65536;
    localparam int FULL_VOLUME_DEFAULT   = 64;

    localparam int POS_W   = 33;
    localparam int STEP_W  = 32;
    localparam int LEN_W   = 17;
    localparam int START_W = 16;
    localparam int RATE_W  = 17;
    localparam int VOL_W   = 8;
    localparam int DIV_W   = 32;
    localparam int DVS_W   = 17;
    localparam int PROD_W  = 25;
    localparam int ADDR_W  = 3;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    typedef struct packed {
        logic load_wr;
        logic start_apply;
        logic step_wr;
        logic clr;
        logic tick_init;
        logic voice_next;
        logic kill;
        logic ram_rd;
        logic mul;
        logic div_go_step;
        logic scale;
        logic mix;
        logic out_load;
    } mvsm_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       need_div;
        logic       v_active;
        logic       v_done;
        logic       v_last;
        logic       div_done;
        logic       out_free;
    } mvsm_stat_t;

    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        if (v > 26'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -26'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/mvsm_ram.sv */
`default_nettype none
module mvsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* hdl/mvsm_div.sv */
`default_nettype none
module mvsm_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      go,
    input  wire logic [mvsm_pkg::DIV_W-1:0] dividend,
    input  wire logic [mvsm_pkg::DVS_W-1:0] divisor,
    output      logic                      done,
    output      logic [mvsm_pkg::DIV_W-1:0] quotient
);
    import mvsm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dsr_reg, dsr_next;
    logic [DIV_W-1:0]   q_reg, q_next;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     diff;
    logic               ge;

    always_comb
    begin
        trial     = {rem_reg, q_reg[DIV_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            q_next    = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

/* hdl/mvsm_ctrl.sv */
`default_nettype none
module mvsm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire mvsm_pkg::mvsm_stat_t stat,
    output      mvsm_pkg::mvsm_cmd_t  cmd
);
    import mvsm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SDIV,
        S_VCHK,
        S_VRD,
        S_VSCL,
        S_VMIX,
        S_NEXT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_LOAD:
                    begin
                        cmd.load_wr = 1'b1;
                        state_next  = S_IDLE;
                    end
                    OP_START:
                    begin
                        cmd.start_apply = 1'b1;
                        if (stat.need_div)
                        begin
                            cmd.div_go_step = 1'b1;
                            state_next      = S_SDIV;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_TICK:
                    begin
                        cmd.tick_init = 1'b1;
                        state_next    = S_VCHK;
                    end
                    default:
                    begin
                        cmd.clr    = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.step_wr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_VCHK:
            begin
                if (!stat.v_active)
                begin
                    state_next = S_NEXT;
                end
                else if (stat.v_done)
                begin
                    cmd.kill   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = S_VRD;
                end
            end
            S_VRD:
            begin
                cmd.mul    = 1'b1;
                state_next = S_VSCL;
            end
            S_VSCL:
            begin
                cmd.scale  = 1'b1;
                state_next = S_VMIX;
            end
            S_VMIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (stat.v_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.voice_next = 1'b1;
                    state_next     = S_VCHK;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/mvsm_dp.sv */
`default_nettype none
module mvsm_dp #(
    parameter int VOICES        = mvsm_pkg::VOICES_DEFAULT,
    parameter int FRACTION_BITS = mvsm_pkg::FRACTION_BITS_DEFAULT,
    parameter int SAMPLE_WORDS  = mvsm_pkg::SAMPLE_WORDS_DEFAULT,
    parameter int FULL_VOLUME   = mvsm_pkg::FULL_VOLUME_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take,
    input  wire logic [1:0]                 operation,
    input  wire logic [15:0]                mem_address,
    input  wire logic signed [7:0]          mem_byte,
    input  wire logic [15:0]                sound_start,
    input  wire logic [16:0]                sound_length,
    input  wire logic [15:0]                sound_rate_hz,
    input  wire logic [7:0]                 sound_volume,
    input  wire logic signed [15:0]         premix_left,
    input  wire logic signed [15:0]         premix_right,
    input  wire logic                       cfg_wr,
    input  wire logic [mvsm_pkg::ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]                cfg_wdata,
    output      logic [31:0]                cfg_rdata,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      logic signed [15:0]         mixed_left,
    output      logic signed [15:0]         mixed_right,
    output      logic [3:0]                 active_voices,
    input  wire mvsm_pkg::mvsm_cmd_t        cmd,
    output      mvsm_pkg::mvsm_stat_t       stat
);
    import mvsm_pkg::*;

    localparam int AW     = $clog2(SAMPLE_WORDS);
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACT_W  = (VOICES > 4) ? VOICES : 4;
    localparam int MAG_W  = PROD_W - 1;
    localparam int REC_W  = MAG_W + 2;
    localparam int SCL_W  = MAG_W + REC_W;
    localparam int VSHIFT = MAG_W + $clog2(FULL_VOLUME);
    localparam logic [REC_W-1:0] VRECIP =
        REC_W'(((64'd1 << VSHIFT) + 64'(FULL_VOLUME) - 64'd1) / 64'(FULL_VOLUME));

    logic [1:0]               op_reg;
    logic [15:0]              maddr_reg;
    logic [7:0]               mbyte_reg;
    logic [START_W-1:0]       sstart_reg;
    logic [LEN_W-1:0]         slen_reg;
    logic [15:0]              srate_reg;
    logic [VOL_W-1:0]         svol_reg;
    logic signed [15:0]       pl_reg, pr_reg;

    logic [RATE_W-1:0]        rate_reg;

    logic [VOICES-1:0]        act_reg;
    logic [START_W-1:0]       vstart_reg [VOICES];
    logic [LEN_W-1:0]         vlen_reg   [VOICES];
    logic [POS_W-1:0]         vpos_reg   [VOICES];
    logic [STEP_W-1:0]        vstep_reg  [VOICES];
    logic [VOL_W-1:0]         vvol_reg   [VOICES];

    logic [VW-1:0]            v_reg;
    logic [VW-1:0]            claim_reg;
    logic signed [15:0]       left_reg, right_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0]         scale_reg;

    logic                     out_valid_reg;
    logic signed [15:0]       oleft_reg, oright_reg;
    logic [3:0]               omask_reg;

    logic                     hit_any, free_any;
    logic [VW-1:0]            hit_idx, free_idx;

    logic [POS_W-1:0]         ipos;
    logic [POS_W-1:0]         addr_sum;
    logic [POS_W-1:0]         waddr_ext;
    logic [7:0]               rdata;
    logic signed [15:0]       wide;
    logic signed [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0]        mag;
    logic [SCL_W-1:0]         scl_prod;
    logic                     div_go;
    logic [DIV_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dsr;
    logic                     div_done;
    logic [DIV_W-1:0]         quot;
    logic signed [PROD_W-1:0] smp;
    logic signed [25:0]       lsum, rsum;
    logic [POS_W:0]           np;
    logic [POS_W-1:0]         pos_upd;
    logic [ACT_W-1:0]         act_pad;

    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (act_reg[i] && vstart_reg[i] == sstart_reg)
            begin
                hit_any = 1'b1;
                hit_idx = VW'(i);
            end
            if (!act_reg[i])
            begin
                free_any = 1'b1;
                free_idx = VW'(i);
            end
        end
    end

    assign ipos      = vpos_reg[v_reg] >> FRACTION_BITS;
    assign addr_sum  = {{(POS_W-START_W){1'b0}}, vstart_reg[v_reg]} + ipos;
    assign waddr_ext = {{(POS_W-16){1'b0}}, maddr_reg};
    assign wide      = {rdata, rdata ^ 8'h80};
    assign prod_next = wide * $signed({1'b0, vvol_reg[v_reg]});
    assign mag       = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign scl_prod  = SCL_W'(mag[MAG_W-1:0]) * SCL_W'(VRECIP);

    assign div_go  = cmd.div_go_step;
    assign div_dvd = DIV_W'({srate_reg, {FRACTION_BITS{1'b0}}});
    assign div_dsr = rate_reg;

    assign smp  = prod_reg[PROD_W-1] ? -$signed({1'b0, scale_reg})
                                     : $signed({1'b0, scale_reg});
    assign lsum = 26'(left_reg) + 26'(smp);
    assign rsum = 26'(right_reg) + 26'(smp);
    assign np   = {1'b0, vpos_reg[v_reg]} + {{(POS_W+1-STEP_W){1'b0}}, vstep_reg[v_reg]};
    assign pos_upd = np[POS_W] ? {POS_W{1'b1}} : np[POS_W-1:0];
    assign act_pad = ACT_W'(act_reg);

    mvsm_ram #(
        .WIDTH (8),
        .DEPTH (SAMPLE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_wr),
        .waddr (waddr_ext[AW-1:0]),
        .wdata (mbyte_reg),
        .re    (cmd.ram_rd),
        .raddr (addr_sum[AW-1:0]),
        .rdata (rdata)
    );

    mvsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg     <= operation;
            maddr_reg  <= mem_address;
            mbyte_reg  <= mem_byte;
            sstart_reg <= sound_start;
            slen_reg   <= sound_length;
            srate_reg  <= sound_rate_hz;
            svol_reg   <= sound_volume;
            pl_reg     <= premix_left;
            pr_reg     <= premix_right;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.scale)
        begin
            scale_reg <= MAG_W'(scl_prod >> VSHIFT);
        end
        if (cmd.start_apply)
        begin
            claim_reg <= free_idx;
        end
        if (cmd.tick_init)
        begin
            left_reg  <= pl_reg;
            right_reg <= pr_reg;
        end
        else if (cmd.mix)
        begin
            left_reg  <= sat16(lsum);
            right_reg <= sat16(rsum);
        end
        if (cmd.out_load)
        begin
            oleft_reg  <= left_reg;
            oright_reg <= right_reg;
            omask_reg  <= act_pad[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RESET;
            act_reg       <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                vstart_reg[i] <= '0;
                vlen_reg[i]   <= '0;
                vpos_reg[i]   <= '0;
                vstep_reg[i]  <= '0;
                vvol_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_wr && !cfg_addr[2])
            begin
                rate_reg <= cfg_wdata[RATE_W-1:0];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.tick_init)
            begin
                v_reg <= '0;
            end
            else if (cmd.voice_next)
            begin
                v_reg <= v_reg + 1'b1;
            end
            if (cmd.clr)
            begin
                act_reg <= '0;
                for (int i = 0; i < VOICES; i++)
                begin
                    vstart_reg[i] <= '0;
                    vlen_reg[i]   <= '0;
                    vpos_reg[i]   <= '0;
                    vstep_reg[i]  <= '0;
                    vvol_reg[i]   <= '0;
                end
            end
            if (cmd.start_apply)
            begin
                if (hit_any)
                begin
                    vpos_reg[hit_idx] <= '0;
                    vvol_reg[hit_idx] <= svol_reg;
                end
                else if (free_any)
                begin
                    act_reg[free_idx]    <= 1'b1;
                    vvol_reg[free_idx]   <= svol_reg;
                    vstart_reg[free_idx] <= sstart_reg;
                    vlen_reg[free_idx]   <= slen_reg;
                    vpos_reg[free_idx]   <= '0;
                end
            end
            if (cmd.step_wr)
            begin
                vstep_reg[claim_reg] <= quot;
            end
            if (cmd.kill)
            begin
                act_reg[v_reg] <= 1'b0;
            end
            if (cmd.mix)
            begin
                vpos_reg[v_reg] <= pos_upd;
            end
        end
    end

    always_comb
    begin
        stat          = '0;
        stat.op       = op_reg;
        stat.need_div = !hit_any && free_any;
        stat.v_active = act_reg[v_reg];
        stat.v_done   = ipos >= {{(POS_W-LEN_W){1'b0}}, vlen_reg[v_reg]};
        stat.v_last   = v_reg == VW'(VOICES - 1);
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign cfg_rdata     = cfg_addr[2] ? 32'd0 : 32'(rate_reg);
    assign out_valid     = out_valid_reg;
    assign mixed_left    = oleft_reg;
    assign mixed_right   = oright_reg;
    assign active_voices = omask_reg;

endmodule
`default_nettype wire

/* hdl/multi_voice_sample_mixer.sv */
// Load and stop go back to idle after decode, as do a restart and a dropped start; a
// start claiming a free voice waits for the 32-step divider that forms the voice step.
// Tick: idle voices are skipped, expiring ones stopped, playing ones read and mixed; the
// output may wait for out_ready; volume scaling is a reciprocal multiply. One item
// at a time. Reset clears all voices and the output beat; output_rate resets to 44100.
// Sample memory is not cleared and holds no data until loaded.
`default_nettype none
module multi_voice_sample_mixer #(
    parameter int VOICES        = mvsm_pkg::VOICES_DEFAULT,
    parameter int FRACTION_BITS = mvsm_pkg::FRACTION_BITS_DEFAULT,
    parameter int SAMPLE_WORDS  = mvsm_pkg::SAMPLE_WORDS_DEFAULT,
    parameter int FULL_VOLUME   = mvsm_pkg::FULL_VOLUME_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mvsm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic [1:0]                  operation,
    input  wire logic [15:0]                 mem_address,
    input  wire logic signed [7:0]           mem_byte,
    input  wire logic [15:0]                 sound_start,
    input  wire logic [16:0]                 sound_length,
    input  wire logic [15:0]                 sound_rate_hz,
    input  wire logic [7:0]                  sound_volume,
    input  wire logic signed [15:0]          premix_left,
    input  wire logic signed [15:0]          premix_right,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic signed [15:0]          mixed_left,
    output      logic signed [15:0]          mixed_right,
    output      logic [3:0]                  active_voices
);
    import mvsm_pkg::*;

    mvsm_cmd_t  cmd;
    mvsm_stat_t stat;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    mvsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mvsm_dp #(
        .VOICES        (VOICES),
        .FRACTION_BITS (FRACTION_BITS),
        .SAMPLE_WORDS  (SAMPLE_WORDS),
        .FULL_VOLUME   (FULL_VOLUME)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (in_valid && in_ready),
        .operation     (operation),
        .mem_address   (mem_address),
        .mem_byte      (mem_byte),
        .sound_start   (sound_start),
        .sound_length  (sound_length),
        .sound_rate_hz (sound_rate_hz),
        .sound_volume  (sound_volume),
        .premix_left   (premix_left),
        .premix_right  (premix_right),
        .cfg_wr        (cfg_wr),
        .cfg_addr      (paddr),
        .cfg_wdata     (pwdata),
        .cfg_rdata     (prdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mixed_left    (mixed_left),
        .mixed_right   (mixed_right),
        .active_voices (active_voices),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
`default_nettype wire
